/* src/tnps_pkg.sv */
// Shared widths, codes and word layouts of the two-nearest prototype search.
package tnps_pkg;

    localparam int CELL_W     = 6;
    localparam int COMP_W     = 3;
    localparam int VAL_W      = 16;
    localparam int IDX_W      = 6;
    localparam int DIST_W     = 35;
    localparam int SQ_W       = 2 * VAL_W;

    localparam int IN_FIELDS_W  = CELL_W + COMP_W + VAL_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * IDX_W + 2 * DIST_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam int CELLS_W    = 7;
    localparam int DIMS_W     = 4;

    localparam logic OP_PROTO  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_CELLS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_DIMS  = 2'd1;

    localparam logic [CELLS_W-1:0] CELLS_RESET = 7'd2;
    localparam logic [DIMS_W-1:0]  DIMS_RESET  = 4'd8;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [IDX_W-1:0]  t_idx;

endpackage

/* src/tnps_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
module tnps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/two_nearest_prototype_search.sv */
// Top level of the two-nearest prototype search.
//
// Prototype components and sample components arrive as input words, one
// component per word, and input words are taken only while the block is
// idle. The word that carries the last sample component starts a scan
// over the active cells. The prototype memory has one read port, so the scan
// reads one component of one cell per cycle. The result word becomes valid
// when the scan has passed the read, difference, square and sum registers
// and the two-nearest ranking, and no input word is taken in between. A
// finished result waits in an output register, and the block takes new
// input words while it waits there. A later search that finishes before
// that result is taken holds the input until the output register is free.
// Squared distances are exact and saturate at 2^35-1; on a tie the lower
// cell index wins. Memory contents are undefined until written.
module two_nearest_prototype_search import tnps_pkg::*; #(
    parameter int MAX_CELLS = 64,
    parameter int MAX_DIMS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cell_index, component_index, component_value, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                  s_axis_tuser,
    // sample_last
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // winner_index, runner_up_index, winner_distance, runner_up_distance, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CW    = $clog2(MAX_CELLS);
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int AW    = $clog2(MAX_CELLS * MAX_DIMS);
    localparam int SUM_W = (33 + $clog2(MAX_DIMS) > DIST_W) ? 33 + $clog2(MAX_DIMS) : DIST_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CELLS_W-1:0] r_active_cells;
    logic [DIMS_W-1:0]  r_active_dims;

    logic [CELL_W-1:0]  in_cell;
    logic [COMP_W-1:0]  in_comp;
    logic [VAL_W-1:0]   in_value;
    logic               in_acc;
    logic               in_cell_ok;
    logic               in_comp_ok;
    logic               proto_we;
    logic               sample_we;
    logic               start;
    logic [AW-1:0]      proto_waddr;

    logic [CW-1:0]      last_cell;
    logic [DW-1:0]      last_dim;

    logic [CW-1:0]      r_c;
    logic [DW-1:0]      r_d;
    logic [AW-1:0]      r_base;
    logic               issue_vld;
    logic               issue_last;
    logic               issue_final;
    logic [AW-1:0]      proto_raddr;
    logic [VAL_W-1:0]   proto_q;
    logic [VAL_W-1:0]   sample_q;

    logic               r_p1_vld;
    logic               r_p1_first;
    logic               r_p1_last;
    logic               r_p1_final;
    logic [CW-1:0]      r_p1_cell;
    logic               r_p2_vld;
    logic               r_p2_first;
    logic               r_p2_last;
    logic               r_p2_final;
    logic [CW-1:0]      r_p2_cell;
    logic signed [VAL_W:0] r_diff;
    logic               r_p3_vld;
    logic               r_p3_first;
    logic               r_p3_last;
    logic               r_p3_final;
    logic [CW-1:0]      r_p3_cell;
    logic [SQ_W-1:0]    r_sq;
    logic signed [2*VAL_W+1:0] sq_full;
    logic [SUM_W-1:0]   r_acc;
    logic [SUM_W-1:0]   n_acc;
    logic               r_p4_vld;
    logic               r_p4_final;
    logic [CW-1:0]      r_p4_cell;
    t_dist              cur_dist;

    logic               r_have1;
    logic               r_have2;
    t_dist              r_d1;
    t_dist              r_d2;
    logic [CW-1:0]      r_i1;
    logic [CW-1:0]      r_i2;

    logic               r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic               out_load;

    assign in_cell  = s_axis_tdata[CELL_W-1:0];
    assign in_comp  = s_axis_tdata[CELL_W +: COMP_W];
    assign in_value = s_axis_tdata[CELL_W + COMP_W +: VAL_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_cell_ok    = int'(in_cell) < MAX_CELLS;
    assign in_comp_ok    = int'(in_comp) < MAX_DIMS;
    assign proto_we      = in_acc && (s_axis_tuser == OP_PROTO) && in_cell_ok && in_comp_ok;
    assign sample_we     = in_acc && (s_axis_tuser == OP_SAMPLE) && in_comp_ok;
    assign start         = in_acc && (s_axis_tuser == OP_SAMPLE) && s_axis_tlast;
    assign proto_waddr   = AW'(int'(in_cell) * MAX_DIMS + int'(in_comp));

    assign last_cell = (r_active_cells < 7'd2) ? CW'(1) :
                       (int'(r_active_cells) > MAX_CELLS) ? CW'(MAX_CELLS - 1) :
                       CW'(r_active_cells - 7'd1);
    assign last_dim  = (r_active_dims == 4'd0) ? DW'(0) :
                       (int'(r_active_dims) > MAX_DIMS) ? DW'(MAX_DIMS - 1) :
                       DW'(r_active_dims - 4'd1);

    assign issue_vld   = (r_state == ST_SCAN);
    assign issue_last  = (r_d == last_dim);
    assign issue_final = issue_last && (r_c == last_cell);
    assign proto_raddr = r_base + AW'(r_d);

    tnps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_CELLS * MAX_DIMS)
    ) u_proto_ram (
        .i_clk   (i_clk),
        .i_we    (proto_we),
        .i_waddr (proto_waddr),
        .i_wdata (in_value),
        .i_raddr (proto_raddr),
        .o_rdata (proto_q)
    );

    tnps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_DIMS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (sample_we),
        .i_waddr (DW'(in_comp)),
        .i_wdata (in_value),
        .i_raddr (r_d),
        .o_rdata (sample_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_cells <= CELLS_RESET;
            r_active_dims  <= DIMS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ACTIVE_CELLS: r_active_cells <= i_cfg_wdata[CELLS_W-1:0];
                REG_ACTIVE_DIMS:  r_active_dims  <= i_cfg_wdata[DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_load = (r_state == ST_DONE) && (!r_out_vld || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_SCAN;
            ST_SCAN:  if (issue_final) n_state = ST_DRAIN;
            ST_DRAIN: if (r_p4_vld && r_p4_final) n_state = ST_DONE;
            ST_DONE:  if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c    <= '0;
            r_d    <= '0;
            r_base <= '0;
        end else if (start) begin
            r_c    <= '0;
            r_d    <= '0;
            r_base <= '0;
        end else if (issue_vld) begin
            if (issue_last) begin
                r_d    <= '0;
                r_c    <= r_c + CW'(1);
                r_base <= r_base + AW'(MAX_DIMS);
            end else begin
                r_d <= r_d + DW'(1);
            end
        end
    end

    assign sq_full  = r_diff * r_diff;
    assign n_acc    = r_p3_first ? SUM_W'(r_sq) : r_acc + SUM_W'(r_sq);
    assign cur_dist = (r_acc > SUM_W'(DIST_MAX)) ? DIST_MAX : r_acc[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
        end else begin
            r_p1_vld <= issue_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld && r_p3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_first <= (r_d == '0);
        r_p1_last  <= issue_last;
        r_p1_final <= issue_final;
        r_p1_cell  <= r_c;

        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_final <= r_p1_final;
        r_p2_cell  <= r_p1_cell;
        r_diff     <= $signed({sample_q[VAL_W-1], sample_q}) -
                      $signed({proto_q[VAL_W-1], proto_q});

        r_p3_first <= r_p2_first;
        r_p3_last  <= r_p2_last;
        r_p3_final <= r_p2_final;
        r_p3_cell  <= r_p2_cell;
        r_sq       <= sq_full[SQ_W-1:0];

        if (r_p3_vld) begin
            r_acc <= n_acc;
        end
        r_p4_final <= r_p3_final;
        r_p4_cell  <= r_p3_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have1 <= 1'b0;
            r_have2 <= 1'b0;
        end else if (start) begin
            r_have1 <= 1'b0;
            r_have2 <= 1'b0;
        end else if (r_p4_vld) begin
            if (!r_have1 || cur_dist < r_d1) begin
                r_have1 <= 1'b1;
                if (r_have1) begin
                    r_have2 <= 1'b1;
                end
            end else if (!r_have2 || cur_dist < r_d2) begin
                r_have2 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p4_vld) begin
            if (!r_have1 || cur_dist < r_d1) begin
                if (r_have1) begin
                    r_d2 <= r_d1;
                    r_i2 <= r_i1;
                end
                r_d1 <= cur_dist;
                r_i1 <= r_p4_cell;
            end else if (!r_have2 || cur_dist < r_d2) begin
                r_d2 <= cur_dist;
                r_i2 <= r_p4_cell;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= OUT_DATA_W'({r_d2, r_d1, IDX_W'(r_i2), IDX_W'(r_i1)});
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

/* src/tnps_chk.sv */
// Port-level checker of the two-nearest prototype search, bound to the top level.
module tnps_chk import tnps_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_idx  win_idx;
    t_idx  run_idx;
    t_dist win_dist;
    t_dist run_dist;

    assign win_idx  = m_axis_tdata[IDX_W-1:0];
    assign run_idx  = m_axis_tdata[IDX_W +: IDX_W];
    assign win_dist = m_axis_tdata[2*IDX_W +: DIST_W];
    assign run_dist = m_axis_tdata[2*IDX_W + DIST_W +: DIST_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_dist_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> win_dist <= run_dist)
        else $error("winner distance exceeds runner-up distance");

    a_idx_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> win_idx != run_idx)
        else $error("winner and runner-up are the same cell");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

endmodule

bind two_nearest_prototype_search tnps_chk u_tnps_chk (.*);

/* dv/two_nearest_prototype_search_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the two-nearest prototype search with its own distance predictor.
module two_nearest_prototype_search_tb;
    import tnps_pkg::*;

    localparam int NUM_CELLS     = 64;
    localparam int NUM_DIMS      = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS   = 120;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [VAL_W-1:0] VAL_MOST_NEG = 16'h8000;
    localparam logic [VAL_W-1:0] VAL_MOST_POS = 16'h7FFF;

    // Field order is reversed so that the packed struct matches the result word layout.
    typedef struct packed {
        t_dist runner_up_dist;
        t_dist winner_dist;
        t_idx  runner_up;
        t_idx  winner;
    } t_match;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [VAL_W-1:0]   proto_mem [NUM_CELLS][NUM_DIMS];
    logic [VAL_W-1:0]   sample_vec [NUM_DIMS];
    logic [CELLS_W-1:0] cells_cfg;
    logic [DIMS_W-1:0]  dims_cfg;
    t_match             expected_matches [$];
    int                 errors;
    bit                 quiet;

    two_nearest_prototype_search #(
        .MAX_CELLS(NUM_CELLS),
        .MAX_DIMS (NUM_DIMS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("two_nearest_prototype_search_tb: FAIL");
        $finish;
    end

    function automatic int scan_cells();
        int n;
        n = cells_cfg;
        if (n < 2) n = 2;
        if (n > NUM_CELLS) n = NUM_CELLS;
        return n;
    endfunction

    function automatic int scan_dims();
        int n;
        n = dims_cfg;
        if (n < 1) n = 1;
        if (n > NUM_DIMS) n = NUM_DIMS;
        return n;
    endfunction

    function automatic t_dist cell_dist(int c, int dims);
        longint sum;
        int     diff;
        sum = 0;
        for (int d = 0; d < dims; d++) begin
            diff = int'($signed(sample_vec[d])) - int'($signed(proto_mem[c][d]));
            sum += longint'(diff) * longint'(diff);
        end
        if (sum > longint'(DIST_MAX)) sum = longint'(DIST_MAX);
        return t_dist'(sum);
    endfunction

    function automatic void nearest_two();
        t_match m;
        t_dist  cand_dist;
        int     dims;
        bit     have_second;
        dims = scan_dims();
        have_second = 1'b0;
        m.winner = '0;
        m.winner_dist = cell_dist(0, dims);
        m.runner_up = '0;
        m.runner_up_dist = '0;
        for (int c = 1; c < scan_cells(); c++) begin
            cand_dist = cell_dist(c, dims);
            if (cand_dist < m.winner_dist) begin
                m.runner_up = m.winner;
                m.runner_up_dist = m.winner_dist;
                m.winner = t_idx'(c);
                m.winner_dist = cand_dist;
                have_second = 1'b1;
            end else if (!have_second || cand_dist < m.runner_up_dist) begin
                m.runner_up = t_idx'(c);
                m.runner_up_dist = cand_dist;
                have_second = 1'b1;
            end
        end
        expected_matches.push_back(m);
    endfunction

    function automatic void apply_word(logic op, logic [CELL_W-1:0] cell_idx,
                                       logic [COMP_W-1:0] comp, logic [VAL_W-1:0] val,
                                       logic last);
        if (op == OP_PROTO) begin
            proto_mem[cell_idx][comp] = val;
        end else begin
            sample_vec[comp] = val;
            if (last) nearest_two();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return VAL_MOST_NEG;
            1: return VAL_MOST_POS;
            2: return '0;
            3, 4, 5: return VAL_W'($urandom_range(0, 8)) - VAL_W'(4);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_match(t_match got);
        t_match want;
        if (expected_matches.size() == 0) begin
            $display("%0t: result word with none expected, actual %h", $time, got);
            errors++;
            return;
        end
        want = expected_matches.pop_front();
        compare_field("winner_index", want.winner, got.winner);
        compare_field("runner_up_index", want.runner_up, got.runner_up);
        compare_field("winner_distance", want.winner_dist, got.winner_dist);
        compare_field("runner_up_distance", want.runner_up_dist, got.runner_up_dist);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_match(t_match'(m_axis_tdata[OUT_FIELDS_W-1:0]));
        end
    end

    initial begin : ready_gen
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                m_axis_tready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic send_word(input logic op, input logic [CELL_W-1:0] cell_idx,
                             input logic [COMP_W-1:0] comp, input logic [VAL_W-1:0] val,
                             input logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = IN_DATA_W'({val, comp, cell_idx});
        s_axis_tuser = op;
        s_axis_tlast = last;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_word(op, cell_idx, comp, val, last);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = addr;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (addr == REG_ACTIVE_CELLS) cells_cfg = data;
        else if (addr == REG_ACTIVE_DIMS) dims_cfg = data[DIMS_W-1:0];
    endtask

    task automatic send_sample_vector(input logic [VAL_W-1:0] val);
        for (int d = 0; d < NUM_DIMS; d++) begin
            send_word(OP_SAMPLE, CELL_W'($urandom), COMP_W'(d), val, d == NUM_DIMS - 1);
        end
    endtask

    // Every prototype and sample entry is written before any search reads it.
    task automatic test_reset_config();
        for (int c = 0; c < NUM_CELLS; c++) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                send_word(OP_PROTO, CELL_W'(c), COMP_W'(d), rand_value(),
                          logic'($urandom_range(0, 1)));
            end
        end
        for (int d = 0; d < NUM_DIMS; d++) begin
            send_word(OP_SAMPLE, CELL_W'($urandom), COMP_W'(d), rand_value(),
                      d == NUM_DIMS - 1);
        end
    endtask

    task automatic test_extremes();
        write_reg(REG_ACTIVE_CELLS, CFG_DATA_W'(2));
        write_reg(REG_ACTIVE_DIMS, CFG_DATA_W'(NUM_DIMS));
        for (int c = 0; c < 2; c++) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                send_word(OP_PROTO, CELL_W'(c), COMP_W'(d), VAL_MOST_NEG, 1'b0);
            end
        end
        send_sample_vector(VAL_MOST_POS);
        send_word(OP_PROTO, CELL_W'(1), COMP_W'(0), VAL_MOST_POS, 1'b0);
        send_word(OP_SAMPLE, CELL_W'(0), COMP_W'(0), VAL_MOST_POS, 1'b1);
    endtask

    task automatic test_last_marks();
        write_reg(REG_ACTIVE_CELLS, CFG_DATA_W'(NUM_CELLS));
        send_word(OP_SAMPLE, CELL_W'(63), COMP_W'(5), rand_value(), 1'b0);
        send_word(OP_PROTO, CELL_W'(63), COMP_W'(7), rand_value(), 1'b1);
        send_word(OP_SAMPLE, CELL_W'(0), COMP_W'(3), rand_value(), 1'b1);
        send_word(OP_SAMPLE, CELL_W'(21), COMP_W'(0), rand_value(), 1'b1);
    endtask

    task automatic test_register_limits();
        logic [CFG_ADDR_W-1:0] addrs [8];
        logic [CFG_DATA_W-1:0] vals [8];
        addrs = '{REG_ACTIVE_CELLS, REG_ACTIVE_CELLS, REG_ACTIVE_CELLS, REG_ACTIVE_DIMS,
                  REG_ACTIVE_DIMS, REG_ACTIVE_DIMS, REG_SPARE_2, REG_SPARE_3};
        vals = '{7'd0, 7'd1, 7'd127, 7'd0, 7'd15, 7'd9, 7'd127, 7'd0};
        for (int i = 0; i < 8; i++) begin
            write_reg(addrs[i], vals[i]);
            send_word(OP_SAMPLE, CELL_W'($urandom), COMP_W'($urandom), rand_value(), 1'b1);
        end
    endtask

    task automatic send_query();
        int  target;
        int  dims;
        bit  descending;
        bit  near;
        int  d;
        logic [VAL_W-1:0] val;
        target = $urandom_range(0, scan_cells() - 1);
        dims = scan_dims();
        descending = ($urandom_range(0, 99) < 30);
        near = $urandom_range(0, 1);
        for (int k = 0; k < dims; k++) begin
            d = descending ? dims - 1 - k : k;
            if (near) val = proto_mem[target][d] + VAL_W'($urandom_range(0, 6)) - VAL_W'(3);
            else val = rand_value();
            send_word(OP_SAMPLE, CELL_W'($urandom), COMP_W'(d), val, k == dims - 1);
        end
    endtask

    task automatic test_random();
        int cells_list [8];
        int dims_list [8];
        int sent;
        int r;
        cells_list = '{2, 64, 5, 33, 64, 2, 17, 0};
        dims_list = '{1, 8, 3, 8, 1, 8, 5, 0};
        cells_list[7] = $urandom_range(0, 127);
        dims_list[7] = $urandom_range(0, 15);
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_ACTIVE_CELLS, CFG_DATA_W'(cells_list[p]));
            write_reg(REG_ACTIVE_DIMS, CFG_DATA_W'(dims_list[p]));
            quiet = (p == 2 || p == 5);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    send_query();
                    sent += scan_dims();
                end else if (r < 85) begin
                    send_word(OP_PROTO, CELL_W'($urandom_range(0, scan_cells() - 1)),
                              COMP_W'($urandom), rand_value(), logic'($urandom_range(0, 1)));
                    sent++;
                end else if (r < 90) begin
                    send_word(OP_PROTO, CELL_W'($urandom), COMP_W'($urandom), VAL_W'($urandom),
                              logic'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    send_word(OP_SAMPLE, CELL_W'($urandom), COMP_W'($urandom), rand_value(),
                              logic'($urandom_range(0, 1)));
                    sent++;
                end
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        errors = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_PROTO;
        s_axis_tlast = 1'b0;
        cells_cfg = CELLS_RESET;
        dims_cfg = DIMS_RESET;
        for (int c = 0; c < NUM_CELLS; c++) begin
            for (int d = 0; d < NUM_DIMS; d++) proto_mem[c][d] = '0;
        end
        for (int d = 0; d < NUM_DIMS; d++) sample_vec[d] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_config();
        test_extremes();
        test_last_marks();
        test_register_limits();
        test_random();

        settle();
        if (errors == 0) begin
            $display("two_nearest_prototype_search_tb: PASS");
        end else begin
            $display("two_nearest_prototype_search_tb: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/tnps_pkg.sv
src/tnps_ram.sv
src/two_nearest_prototype_search.sv
src/tnps_chk.sv
dv/two_nearest_prototype_search_tb.sv
